/* rtl/variable_record_byte_stack_defines.svh */
// ----------------------------------------------------------------------------
// variable_record_byte_stack_defines.svh
// Assertion macros for the record stack RTL.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_RECORD_BYTE_STACK_DEFINES_SVH
`define VARIABLE_RECORD_BYTE_STACK_DEFINES_SVH

// Check a same-cycle implication on clk, skipped while reset is low.
`define VRBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication whose consequent holds in the next cycle on clk, skipped while reset is low.
`define VRBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/vrbs_pkg.sv */
// ----------------------------------------------------------------------------
// vrbs_pkg
// Field widths, request and status codes and the result type of the stack.
// ----------------------------------------------------------------------------
package vrbs_pkg;

  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;

  // Request modes
  localparam logic [1:0] MODE_PUSH_HDR  = 2'd0;
  localparam logic [1:0] MODE_PUSH_DATA = 2'd1;
  localparam logic [1:0] MODE_PEEK      = 2'd2;
  localparam logic [1:0] MODE_CLEAR     = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef struct packed {
    logic [1:0]        status;
    logic [BYTE_W-1:0] data;
    logic              data_valid;
    logic              last;
    logic              is_empty;
  } result_t;

endpackage

/* rtl/vrbs_out_stage.sv */
// ----------------------------------------------------------------------------
// vrbs_out_stage
// Result holding register: keeps one result until the consumer takes it.
// ----------------------------------------------------------------------------
module vrbs_out_stage
  import vrbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_i,
  input  result_t           res_i,
  output logic              free_o,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [BYTE_W-1:0] out_data_out,
  output logic              out_data_valid,
  output logic              out_last,
  output logic              out_is_empty
);

  logic    valid_r;
  result_t res_r;

  // The slot can take a result when empty or when it drains this cycle
  assign free_o = !valid_r || out_ready;

  // Hold the valid flag until the result is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_i) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Capture the payload on load
  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

  assign out_valid      = valid_r;
  assign out_status     = res_r.status;
  assign out_data_out   = res_r.data;
  assign out_data_valid = res_r.data_valid;
  assign out_last       = res_r.last;
  assign out_is_empty   = res_r.is_empty;

endmodule

/* rtl/variable_record_byte_stack.sv */
// ----------------------------------------------------------------------------
// variable_record_byte_stack
// Downward-growing byte stack of length-prefixed records in one byte RAM.
//
//   channel | direction | handshake            | fields
//   in_     | input     | in_valid / in_ready  | mode, length, data_in
//   out_    | output    | out_valid / out_ready| status, data_out, data_valid,
//           |           |                      | last, is_empty
//
// Data byte, clear and refused or empty requests are answered from idle.
// Push header then writes HEADER_BYTES header bytes in the header state: the
// RAM has one write port and writes one header byte per cycle.
// Peek of n bytes makes one registered RAM read per cycle and gives one
// result per cycle while out_ready stays high.
// Synchronous active-low reset empties the stack at once; the RAM itself is
// not cleared. A stalled output holds the peek read stream in place.
// ----------------------------------------------------------------------------
`include "variable_record_byte_stack_defines.svh"

module variable_record_byte_stack
  import vrbs_pkg::*;
#(
  parameter int CAPACITY     = 64,
  parameter int HEADER_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [LEN_W-1:0]  in_length,
  input  logic [BYTE_W-1:0] in_data_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [BYTE_W-1:0] out_data_out,
  output logic              out_data_valid,
  output logic              out_last,
  output logic              out_is_empty
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int TW  = $clog2(CAPACITY + 1);
  localparam int SW  = ((TW > LEN_W) ? TW : LEN_W) + 1;
  localparam int HCW = $clog2(HEADER_BYTES + 1);

  localparam logic [TW-1:0]  TOP_EMPTY = TW'(CAPACITY);
  localparam logic [SW-1:0]  HDR_S     = SW'(HEADER_BYTES);
  localparam logic [HCW-1:0] HCNT_LAST = HCW'(HEADER_BYTES - 1);
  localparam logic [AW-1:0]  FILL_LAST = AW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_HDR  = 3'b010,
    S_PEEK = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [TW-1:0]     top_r, top_nxt;
  logic [AW-1:0]     fill_r, fill_nxt;
  logic [LEN_W-1:0]  pend_r, pend_nxt;
  logic [LEN_W-1:0]  top_len_r, top_len_nxt;
  logic [HCW-1:0]    hcnt_r, hcnt_nxt;
  logic [LEN_W-1:0]  rd_cnt_r, rd_cnt_nxt;
  logic [LEN_W-1:0]  peek_n_r, peek_n_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [BYTE_W-1:0] rd_data_r;

  logic [BYTE_W-1:0] mem [CAPACITY];

  logic              in_acc;
  logic              out_free;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [BYTE_W-1:0] mem_wd;
  logic              rd_issue;
  logic [AW-1:0]     rd_addr;
  logic              peek_load;
  logic              peek_done;
  logic              res_load;
  result_t           res;
  logic [SW-1:0]     top_s;
  logic [SW-1:0]     len_s;
  logic              is_full;
  logic              stack_empty;
  logic [LEN_W-1:0]  peek_n;

  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;

  assign top_s       = SW'(top_r);
  assign len_s       = SW'(in_length);
  assign is_full     = top_s < (HDR_S + len_s);
  assign stack_empty = (top_r == TOP_EMPTY);
  assign peek_n      = (top_len_r < in_length) ? top_len_r : in_length;

  // Peek stream: one read outstanding, drained into the output slot
  assign rd_addr   = AW'(top_s + HDR_S + SW'(rd_cnt_r));
  assign peek_load = (state_r == S_PEEK) && rd_pend_r && out_free;
  assign peek_done = peek_load && (rd_cnt_r == peek_n_r);
  assign rd_issue  = (state_r == S_PEEK) && (rd_cnt_r != peek_n_r) &&
                     (!rd_pend_r || out_free);

  // Decode requests and sequence header writes and peek reads
  always_comb begin
    state_nxt   = state_r;
    top_nxt     = top_r;
    fill_nxt    = fill_r;
    pend_nxt    = pend_r;
    top_len_nxt = top_len_r;
    hcnt_nxt    = hcnt_r;
    rd_cnt_nxt  = rd_cnt_r;
    peek_n_nxt  = peek_n_r;
    rd_pend_nxt = rd_pend_r;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    res_load    = 1'b0;
    res         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_load     = 1'b1;
          res.last     = 1'b1;
          res.status   = ST_OK;
          res.is_empty = stack_empty;
          unique case (in_mode)
            MODE_PUSH_HDR: begin
              if (is_full) begin
                res.status = ST_FULL;
              end else begin
                top_nxt      = TW'(top_s - len_s - HDR_S);
                fill_nxt     = AW'(top_s - len_s);
                pend_nxt     = in_length;
                top_len_nxt  = in_length;
                hcnt_nxt     = '0;
                state_nxt    = S_HDR;
                res.is_empty = 1'b0;
              end
            end
            MODE_PUSH_DATA: begin
              if (pend_r == '0) begin
                res.status = ST_IGNORED;
              end else begin
                mem_we   = 1'b1;
                mem_wa   = fill_r;
                mem_wd   = in_data_in;
                fill_nxt = (fill_r == FILL_LAST) ? '0 : fill_r + 1'b1;
                pend_nxt = pend_r - 1'b1;
              end
            end
            MODE_PEEK: begin
              if (stack_empty) begin
                res.status = ST_EMPTY;
              end else if (peek_n != '0) begin
                res_load    = 1'b0;
                peek_n_nxt  = peek_n;
                rd_cnt_nxt  = '0;
                rd_pend_nxt = 1'b0;
                state_nxt   = S_PEEK;
              end
            end
            MODE_CLEAR: begin
              top_nxt      = TOP_EMPTY;
              fill_nxt     = '0;
              pend_nxt     = '0;
              top_len_nxt  = '0;
              res.is_empty = 1'b1;
            end
            default: begin
              res.status = ST_OK;
            end
          endcase
        end
      end
      S_HDR: begin
        // Write the little-endian length, low byte first
        mem_we = 1'b1;
        mem_wa = AW'(top_s + SW'(hcnt_r));
        mem_wd = (hcnt_r == '0) ? BYTE_W'(top_len_r) : '0;
        if (hcnt_r == HCNT_LAST) begin
          hcnt_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          hcnt_nxt = hcnt_r + 1'b1;
        end
      end
      S_PEEK: begin
        if (rd_issue) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
        rd_pend_nxt = rd_issue || (rd_pend_r && !out_free);
        if (peek_load) begin
          res_load       = 1'b1;
          res.status     = ST_OK;
          res.data       = rd_data_r;
          res.data_valid = 1'b1;
          res.last       = peek_done;
          res.is_empty   = 1'b0;
        end
        if (peek_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      top_r     <= TOP_EMPTY;
      fill_r    <= '0;
      pend_r    <= '0;
      top_len_r <= '0;
      hcnt_r    <= '0;
      rd_cnt_r  <= '0;
      peek_n_r  <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      top_r     <= top_nxt;
      fill_r    <= fill_nxt;
      pend_r    <= pend_nxt;
      top_len_r <= top_len_nxt;
      hcnt_r    <= hcnt_nxt;
      rd_cnt_r  <= rd_cnt_nxt;
      peek_n_r  <= peek_n_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  // Byte RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  vrbs_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load_i         (res_load),
    .res_i          (res),
    .free_o         (out_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_data_out   (out_data_out),
    .out_data_valid (out_data_valid),
    .out_last       (out_last),
    .out_is_empty   (out_is_empty)
  );

  // An open reservation always belongs to a record on the stack
  `VRBS_ASSERT_NOW(a_pend_nonempty, pend_r != '0, top_r != TOP_EMPTY, "reservation on empty stack")
  // Reads never run past the peek count
  `VRBS_ASSERT_NOW(a_rd_bound, state_r == S_PEEK, rd_cnt_r <= peek_n_r, "peek read overrun")
  // No request is taken while the header is being written
  `VRBS_ASSERT_NOW(a_hdr_block, state_r == S_HDR, !in_ready, "request taken during header write")
  // The final peeked byte returns the block to idle
  `VRBS_ASSERT_NEXT(a_peek_end, peek_done, state_r == S_IDLE, "peek did not finish")

endmodule

/* test/vrbs_checker.sv */
// ----------------------------------------------------------------------------
// vrbs_checker
// Watches both channels of the record stack, predicts the results of every
// accepted request from a mirror of the stack, and compares each accepted
// result with the oldest prediction. Exports the mismatch count and the
// number of results still due.
// ----------------------------------------------------------------------------
module vrbs_checker
  import vrbs_pkg::*;
#(
  parameter int CAPACITY     = 64,
  parameter int HEADER_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [LEN_W-1:0]  in_length,
  input  logic [BYTE_W-1:0] in_data_in,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        out_status,
  input  logic [BYTE_W-1:0] out_data_out,
  input  logic              out_data_valid,
  input  logic              out_last,
  input  logic              out_is_empty,
  output int                fail_count,
  output int                outstanding
);

  localparam int MAX_PEEK     = 60;
  localparam int ADDR_W       = $clog2(CAPACITY);
  localparam int TOP_W        = $clog2(CAPACITY + 1);
  localparam int REPORT_LIMIT = 10;

  // Mirror of the stack
  logic [BYTE_W-1:0] mirror_mem [CAPACITY];
  logic [TOP_W-1:0]  stack_top;
  logic [ADDR_W-1:0] fill_addr;
  logic [LEN_W-1:0]  bytes_owed;

  result_t results_due [$];
  result_t got;
  result_t want;
  int      mismatches;

  // Apply one request to the mirror and queue the results it causes
  function automatic void predict_request(input logic [1:0]        mode,
                                          input logic [LEN_W-1:0]  len,
                                          input logic [BYTE_W-1:0] din);
    result_t     res;
    logic [31:0] stored;
    int          n_bytes;
    int          room;
    res     = '0;
    res.last = 1'b1;
    n_bytes = 0;
    case (mode)
      MODE_PUSH_HDR: begin
        if (stack_top < HEADER_BYTES + len) begin
          res.status = ST_FULL;
        end else begin
          // Reserve the data area, then lay the header below it
          stack_top  = stack_top - len;
          fill_addr  = ADDR_W'(stack_top);
          bytes_owed = len;
          stack_top  = stack_top - HEADER_BYTES;
          for (int i = 0; i < HEADER_BYTES; i++) begin
            mirror_mem[(stack_top + i) % CAPACITY] = BYTE_W'(32'(len) >> (8 * i));
          end
          res.status = ST_OK;
        end
      end
      MODE_PUSH_DATA: begin
        if (bytes_owed == 0) begin
          res.status = ST_IGNORED;
        end else begin
          mirror_mem[fill_addr] = din;
          fill_addr  = fill_addr + 1'b1;
          bytes_owed = bytes_owed - 1'b1;
          res.status = ST_OK;
        end
      end
      MODE_PEEK: begin
        if (stack_top >= CAPACITY) begin
          res.status = ST_EMPTY;
        end else begin
          // Little-endian length header sits at the top address
          stored = '0;
          for (int i = HEADER_BYTES; i > 0; i--) begin
            stored = (stored << 8) | 32'(mirror_mem[(stack_top + i - 1) % CAPACITY]);
          end
          n_bytes = (stored < len) ? int'(stored) : int'(len);
          room    = CAPACITY - int'(stack_top) - HEADER_BYTES;
          if (room < 0) room = 0;
          if (n_bytes > room) n_bytes = room;
          if (n_bytes > MAX_PEEK) n_bytes = MAX_PEEK;
          res.status = ST_OK;
        end
      end
      MODE_CLEAR: begin
        stack_top  = TOP_W'(CAPACITY);
        fill_addr  = '0;
        bytes_owed = '0;
        res.status = ST_OK;
      end
    endcase
    res.is_empty = (stack_top == CAPACITY);
    if (n_bytes == 0) begin
      results_due.push_back(res);
    end else begin
      for (int i = 0; i < n_bytes; i++) begin
        res.data       = mirror_mem[(stack_top + HEADER_BYTES + i) % CAPACITY];
        res.data_valid = 1'b1;
        res.last       = (i == n_bytes - 1);
        results_due.push_back(res);
      end
    end
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf("status=%0d data=%02h data_valid=%0b last=%0b is_empty=%0b",
                     r.status, r.data, r.data_valid, r.last, r.is_empty);
  endfunction

  // Predict on request, compare on result; requests go first so a
  // same-edge result still finds its prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      stack_top  = TOP_W'(CAPACITY);
      fill_addr  = '0;
      bytes_owed = '0;
      for (int i = 0; i < CAPACITY; i++) mirror_mem[i] = '0;
      results_due.delete();
      mismatches = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request(in_mode, in_length, in_data_in);
      end
      if (out_valid && out_ready) begin
        got.status     = out_status;
        got.data       = out_data_out;
        got.data_valid = out_data_valid;
        got.last       = out_last;
        got.is_empty   = out_is_empty;
        if (results_due.size() == 0) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("%0t: result with no request due: %s", $time, fmt_result(got));
          end
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            if (mismatches < REPORT_LIMIT) begin
              $display("%0t: result mismatch: expected %s, got %s",
                       $time, fmt_result(want), fmt_result(got));
            end
            mismatches++;
          end
        end
      end
    end
    fail_count  <= mismatches;
    outstanding <= results_due.size();
  end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives the record stack with a directed set of requests covering empty,
// full, zero-length, abandoned and stray cases, then with random record
// pushes, peeks and clears under random idling on both channels. A separate
// checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top
  import vrbs_pkg::*;
();

  localparam int CAPACITY        = 64;
  localparam int HEADER_BYTES    = 4;
  localparam int MAX_LEN         = 60;
  localparam int TARGET_REQUESTS = 450;
  localparam int QUIET_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 80;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_mode;
  logic [LEN_W-1:0]  in_length;
  logic [BYTE_W-1:0] in_data_in;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_status;
  logic [BYTE_W-1:0] out_data_out;
  logic              out_data_valid;
  logic              out_last;
  logic              out_is_empty;

  int fail_count;
  int outstanding;
  int quiet_cycles;
  int sent;
  bit idle_on;

  // Sender-side view of the stack, used to keep peeks off unwritten bytes
  int plan_top;
  int plan_fill;
  int plan_owed;
  int plan_top_len;
  bit byte_written [CAPACITY];

  always #4 clk = ~clk;

  variable_record_byte_stack #(
    .CAPACITY     (CAPACITY),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_length      (in_length),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_data_out   (out_data_out),
    .out_data_valid (out_data_valid),
    .out_last       (out_last),
    .out_is_empty   (out_is_empty)
  );

  vrbs_checker #(
    .CAPACITY     (CAPACITY),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_length      (in_length),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_data_out   (out_data_out),
    .out_data_valid (out_data_valid),
    .out_last       (out_last),
    .out_is_empty   (out_is_empty),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  // Watchdog: end the run when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("** variable_record_byte_stack: FAILED **");
        $finish;
      end
    end
  end

  // Track the effect of an accepted request; return 1 if it was a stray byte
  function automatic bit track_request(input logic [1:0] mode, input int len);
    bit stray;
    stray = 1'b0;
    case (mode)
      MODE_PUSH_HDR: begin
        if (plan_top >= HEADER_BYTES + len) begin
          plan_top     = plan_top - len;
          plan_fill    = plan_top;
          plan_owed    = len;
          plan_top     = plan_top - HEADER_BYTES;
          plan_top_len = len;
          for (int i = 0; i < HEADER_BYTES; i++) byte_written[plan_top + i] = 1'b1;
        end
      end
      MODE_PUSH_DATA: begin
        if (plan_owed == 0) begin
          stray = 1'b1;
        end else begin
          byte_written[plan_fill % CAPACITY] = 1'b1;
          plan_fill = (plan_fill + 1) % CAPACITY;
          plan_owed--;
        end
      end
      MODE_CLEAR: begin
        plan_top  = CAPACITY;
        plan_fill = 0;
        plan_owed = 0;
      end
      default: begin
      end
    endcase
    return stray;
  endfunction

  // Shorten a peek so it never reads a byte that was never written
  function automatic int safe_peek_length(input int want);
    int n_bytes;
    int ok;
    if (plan_top >= CAPACITY) return want;
    n_bytes = (plan_top_len < want) ? plan_top_len : want;
    ok = 0;
    while (ok < n_bytes && byte_written[plan_top + HEADER_BYTES + ok]) ok++;
    return (ok < n_bytes) ? ok : want;
  endfunction

  // Present one request after a random gap and hold it until accepted
  task automatic send_request(input logic [1:0] mode, input int len, input int din);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode    <= mode;
    in_length  <= LEN_W'(len);
    in_data_in <= BYTE_W'(din);
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (!track_request(mode, len)) sent++;
  endtask

  // Hold off new requests until every predicted result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic send_peek(input int want);
    send_request(MODE_PEEK, safe_peek_length(want), $urandom_range(0, 255));
  endtask

  // Push a record header and its data bytes, sometimes leaving it short
  task automatic push_record(input int len);
    bit fits;
    int n_data;
    fits = (plan_top >= HEADER_BYTES + len);
    send_request(MODE_PUSH_HDR, len, $urandom_range(0, 255));
    if (fits && len > 0) begin
      n_data = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
      repeat (n_data) send_request(MODE_PUSH_DATA, $urandom_range(0, MAX_LEN),
                                   $urandom_range(0, 255));
    end
  endtask

  // Result side: stall a random number of cycles per result
  initial begin : receiver
    int  stall;
    bit  rx_idle;
    out_ready = 1'b0;
    rx_idle   = 1'b1;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_idle = ~rx_idle;
      stall = rx_idle ? $urandom_range(0, 7) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Request side and verdict
  initial begin : sender
    int         pick;
    int         len;
    logic [1:0] mode;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_mode    = MODE_PUSH_HDR;
    in_length  = '0;
    in_data_in = '0;
    idle_on    = 1'b0;
    sent       = 0;
    plan_top   = CAPACITY;
    plan_fill  = 0;
    plan_owed  = 0;
    plan_top_len = 0;
    for (int i = 0; i < CAPACITY; i++) byte_written[i] = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty peek, stray byte, zero-length record, short peeks
    send_request(MODE_PEEK, 5, 0);
    send_request(MODE_PUSH_DATA, 0, 8'hFF);
    send_request(MODE_PUSH_HDR, 0, 0);
    send_request(MODE_PEEK, 10, 0);
    send_request(MODE_PUSH_HDR, 3, 0);
    send_request(MODE_PUSH_DATA, 0, 8'h00);
    send_request(MODE_PUSH_DATA, 0, 8'hFF);
    send_request(MODE_PUSH_DATA, 0, 8'hA5);
    idle_on = 1'b1;
    send_request(MODE_PEEK, MAX_LEN, 0);
    send_request(MODE_PEEK, 0, 0);
    send_request(MODE_PEEK, 2, 0);
    // Abandon a reservation with a new header
    send_request(MODE_PUSH_HDR, 5, 0);
    send_request(MODE_PUSH_DATA, 0, 8'h5A);
    send_request(MODE_PUSH_HDR, 2, 0);
    send_request(MODE_PUSH_DATA, 0, 8'h12);
    send_request(MODE_PUSH_DATA, 0, 8'h34);
    send_request(MODE_PEEK, MAX_LEN, 0);
    // Full, clear, largest record, full at the bottom, stray after clear
    send_request(MODE_PUSH_HDR, MAX_LEN, 0);
    send_request(MODE_CLEAR, 0, 0);
    send_request(MODE_PUSH_HDR, MAX_LEN, 0);
    send_request(MODE_PUSH_DATA, 0, 8'hC3);
    send_request(MODE_PUSH_HDR, 0, 0);
    send_request(MODE_CLEAR, 0, 0);
    send_request(MODE_PUSH_DATA, 0, 8'h7E);
    drain_results();

    // Random: mostly complete records and peeks, with noise mixed in
    while (sent < TARGET_REQUESTS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 99);
      if (pick < 45) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, MAX_LEN)
                                          : $urandom_range(0, 12);
        if (plan_top < HEADER_BYTES + len && $urandom_range(0, 1) == 1) begin
          send_request(MODE_CLEAR, $urandom_range(0, MAX_LEN), $urandom_range(0, 255));
        end
        push_record(len);
        if ($urandom_range(0, 1) == 1) send_peek($urandom_range(0, MAX_LEN));
      end else if (pick < 70) begin
        send_peek(($urandom_range(0, 1) == 1) ? $urandom_range(0, MAX_LEN)
                                              : $urandom_range(0, 15));
      end else if (pick < 78) begin
        send_request(MODE_CLEAR, $urandom_range(0, MAX_LEN), $urandom_range(0, 255));
      end else if (pick < 86) begin
        send_request(MODE_PUSH_DATA, $urandom_range(0, MAX_LEN), $urandom_range(0, 255));
      end else if (pick < 93) begin
        send_request(MODE_PUSH_HDR, $urandom_range(0, MAX_LEN), $urandom_range(0, 255));
      end else begin
        mode = 2'($urandom_range(0, 3));
        len  = $urandom_range(0, MAX_LEN);
        if (mode == MODE_PEEK) len = safe_peek_length(len);
        send_request(mode, len, $urandom_range(0, 255));
      end
      if ($urandom_range(0, 29) == 0) drain_results();
    end

    // Wait out the last results, then give the block time to misbehave
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("** variable_record_byte_stack: PASSED **");
    end else begin
      $display("** variable_record_byte_stack: FAILED **");
    end
    $finish;
  end

endmodule

/* variable_record_byte_stack.f */
+incdir+rtl
rtl/vrbs_pkg.sv
rtl/vrbs_out_stage.sv
rtl/variable_record_byte_stack.sv
test/vrbs_checker.sv
test/tb_top.sv
